// File: hdl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants of the price level depth book.
// ----------------------------------------------------------------------------
`default_nettype none

package plb_pkg;

    // Level counts and level indexes; wide enough for the deepest book supported.
    localparam int unsigned CNT_W = 6;

    typedef enum logic [1:0] {
        OP_NEW     = 2'd0,
        OP_CHANGE  = 2'd1,
        OP_DELETE  = 2'd2,
        OP_INVALID = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_APPLIED        = 3'd0,
        STS_DELETE_MISSING = 3'd1,
        STS_NEW_DUPLICATE  = 3'd2,
        STS_NEW_BEYOND     = 3'd3,
        STS_CHANGE_MISSING = 3'd4,
        STS_INVALID        = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_RESP
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CMP,
        ACT_INS,
        ACT_DEL,
        ACT_CHG
    } t_cell_act;

    typedef struct packed {
        t_cell_act          act;
        logic [1:0]         book;
        logic [CNT_W-1:0]   idx;
        logic [CNT_W-1:0]   hi;
        logic signed [63:0] price;
        logic [30:0]        qty;
    } t_cell_cmd;

endpackage

`default_nettype wire

// File: hdl/plb_in_if.sv
// ----------------------------------------------------------------------------
// plb_in_if
// Update channel: one book update per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface plb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [1:0]         book;
    logic [3:0]         level;
    logic signed [63:0] price;
    logic [30:0]        quantity;
    logic [31:0]        seq;

    modport source (output valid, op, book, level, price, quantity, seq, input ready);
    modport sink   (input valid, op, book, level, price, quantity, seq, output ready);
endinterface

`default_nettype wire

// File: hdl/plb_out_if.sv
// ----------------------------------------------------------------------------
// plb_out_if
// Result channel: status and book summary, one per update.
// ----------------------------------------------------------------------------
`default_nettype none

interface plb_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [63:0] best_price;
    logic [30:0]        best_quantity;
    logic [3:0]         depth_known;
    logic [31:0]        update_count;
    logic               books_were_reset;

    modport source (output valid, status, best_price, best_quantity, depth_known,
                    update_count, books_were_reset, input ready);
    modport sink   (input valid, status, best_price, best_quantity, depth_known,
                    update_count, books_were_reset, output ready);
endinterface

`default_nettype wire

// File: hdl/plb_cfg_if.sv
// ----------------------------------------------------------------------------
// plb_cfg_if
// Configuration write channel for the max depth register.
// ----------------------------------------------------------------------------
`default_nettype none

interface plb_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hdl/plb_cell.sv
// ----------------------------------------------------------------------------
// plb_cell
// One price level of every book; shifts with its neighbors on insert/delete.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_cell #(
    parameter int NUM_BOOKS = 4,
    parameter int CELL_IDX  = 0
) (
    input  wire                      i_clk,
    input  plb_pkg::t_cell_cmd       i_cmd,
    input  wire signed [63:0]        i_left_price,
    input  wire [30:0]               i_left_qty,
    input  wire signed [63:0]        i_right_price,
    input  wire [30:0]               i_right_qty,
    output logic signed [63:0]       o_price,
    output logic [30:0]              o_qty,
    output logic                     o_eq
);

    localparam int unsigned CW = plb_pkg::CNT_W;
    localparam logic [CW-1:0] MY_IDX = CW'(CELL_IDX);

    logic signed [63:0] r_price [NUM_BOOKS];
    logic [30:0]        r_qty   [NUM_BOOKS];
    logic               r_eq;

    logic at_idx;
    logic past_idx;
    logic le_hi;
    logic lt_hi;

    assign at_idx   = (i_cmd.idx == MY_IDX);
    assign past_idx = (MY_IDX > i_cmd.idx);
    assign le_hi    = (MY_IDX <= i_cmd.hi);
    assign lt_hi    = (MY_IDX < i_cmd.hi);

    always_comb begin
        o_price = '0;
        o_qty   = '0;
        for (int b = 0; b < NUM_BOOKS; b++) begin
            if (32'(i_cmd.book) == b) begin
                o_price = r_price[b];
                o_qty   = r_qty[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < NUM_BOOKS; b++) begin
            if (32'(i_cmd.book) == b) begin
                case (i_cmd.act)
                    plb_pkg::ACT_INS: begin
                        if (at_idx) begin
                            r_price[b] <= i_cmd.price;
                            r_qty[b]   <= i_cmd.qty;
                        end else if (past_idx && le_hi) begin
                            r_price[b] <= i_left_price;
                            r_qty[b]   <= i_left_qty;
                        end
                    end
                    plb_pkg::ACT_DEL: begin
                        if ((at_idx || past_idx) && lt_hi) begin
                            r_price[b] <= i_right_price;
                            r_qty[b]   <= i_right_qty;
                        end
                    end
                    plb_pkg::ACT_CHG: begin
                        if (at_idx) begin
                            r_qty[b] <= i_cmd.qty;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (i_cmd.act == plb_pkg::ACT_CMP) begin
            r_eq <= (o_price == i_cmd.price);
        end
    end

    assign o_eq = r_eq;

endmodule

`default_nettype wire

// File: hdl/price_level_depth_book_top.sv
// ----------------------------------------------------------------------------
// price_level_depth_book_top
// Market-by-price depth books kept in a chain of level cells.
// ----------------------------------------------------------------------------
// Channel   Dir  Modport  Contents
// i_in      in   sink     op, book, level, price, quantity, seq
// o_out     out  source   status, best level, depth, update count, reset flag
// i_cfg     in   sink     max depth register write data
//
// An update passes accept (all cells compare their price), apply
// (cells shift or write in one step) and result register load, in that order.
// A result held by a stalled sink lets one more transaction in; that one waits
// in the result step with input ready low until the held result is taken.
// Reset clears depths, update counts and last sequence, and sets max depth to 10.
// Level storage is not cleared; only valid levels are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module price_level_depth_book_top #(
    parameter int MAX_DEPTH = 10,
    parameter int NUM_BOOKS = 4
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    plb_in_if.sink  i_in,
    plb_out_if.source o_out,
    plb_cfg_if.sink i_cfg
);

    localparam int unsigned CW = plb_pkg::CNT_W;
    localparam logic [CW-1:0] MAXD = CW'(MAX_DEPTH);

    plb_pkg::t_state r_state, n_state;

    logic [3:0]         r_max_depth;
    logic [31:0]        r_last;
    plb_pkg::t_op       r_op;
    logic [1:0]         r_book;
    logic [3:0]         r_lvl;
    logic signed [63:0] r_px;
    logic [30:0]        r_qty;
    logic               r_wasreset;
    plb_pkg::t_status   r_status, n_status;
    logic [CW-1:0]      r_valid   [NUM_BOOKS];
    logic [31:0]        r_applied [NUM_BOOKS];

    logic               r_ovalid;
    plb_pkg::t_status   r_ostatus;
    logic signed [63:0] r_oprice;
    logic [30:0]        r_oqty;
    logic [3:0]         r_odepth;
    logic [31:0]        r_ocount;
    logic               r_oreset;

    plb_pkg::t_cell_cmd w_cmd;
    logic signed [63:0] w_price [MAX_DEPTH];
    logic [30:0]        w_qty   [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] w_eq;

    logic          in_acc;
    logic          regress;
    logic          book_ok;
    logic [CW-1:0] cur_n;
    logic [31:0]   cur_cnt;
    logic [CW-1:0] lim;
    logic [CW-1:0] idx;
    logic          eq_idx;
    logic          found;
    logic          upd;
    logic [CW-1:0] new_n;
    logic          inc;
    logic          out_load;

    // ---------------------------------------------------------------- cells
    genvar g;
    for (g = 0; g < MAX_DEPTH; g++) begin : g_cell
        logic signed [63:0] left_p, right_p;
        logic [30:0]        left_q, right_q;
        if (g == 0) begin : g_first
            assign left_p = '0;
            assign left_q = '0;
        end else begin : g_next
            assign left_p = w_price[g-1];
            assign left_q = w_qty[g-1];
        end
        if (g == MAX_DEPTH - 1) begin : g_last
            assign right_p = '0;
            assign right_q = '0;
        end else begin : g_prev
            assign right_p = w_price[g+1];
            assign right_q = w_qty[g+1];
        end
        plb_cell #(
            .NUM_BOOKS (NUM_BOOKS),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_left_price  (left_p),
            .i_left_qty    (left_q),
            .i_right_price (right_p),
            .i_right_qty   (right_q),
            .o_price       (w_price[g]),
            .o_qty         (w_qty[g]),
            .o_eq          (w_eq[g])
        );
    end

    // ------------------------------------------------------------- handshake
    assign i_in.ready  = i_rst_n && (r_state == plb_pkg::ST_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign regress     = (i_in.seq < r_last);
    assign i_cfg.ready = i_rst_n;
    assign out_load    = (r_state == plb_pkg::ST_RESP) && (!r_ovalid || o_out.ready);

    // ------------------------------------------------------ book selection
    always_comb begin
        book_ok = (32'(r_book) < NUM_BOOKS);
        cur_n   = '0;
        cur_cnt = '0;
        for (int b = 0; b < NUM_BOOKS; b++) begin
            if (32'(r_book) == b) begin
                cur_n   = r_valid[b];
                cur_cnt = r_applied[b];
            end
        end
        if (r_max_depth == 4'd0) begin
            lim = CW'(1);
        end else if (CW'(r_max_depth) > MAXD) begin
            lim = MAXD;
        end else begin
            lim = CW'(r_max_depth);
        end
        idx    = CW'(r_lvl) - CW'(1);
        eq_idx = 1'b0;
        found  = 1'b0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (CW'(i) == idx) begin
                eq_idx = w_eq[i];
            end
            if ((CW'(i) < cur_n) && w_eq[i]) begin
                found = 1'b1;
            end
        end
    end

    // ------------------------------------------- update decision and cell cmd
    always_comb begin
        n_state    = r_state;
        n_status   = plb_pkg::STS_INVALID;
        upd        = 1'b0;
        new_n      = cur_n;
        inc        = 1'b0;
        w_cmd.act   = plb_pkg::ACT_NONE;
        w_cmd.book  = r_book;
        w_cmd.idx   = idx;
        w_cmd.hi    = '0;
        w_cmd.price = r_px;
        w_cmd.qty   = r_qty;
        unique case (r_state)
            plb_pkg::ST_IDLE: begin
                w_cmd.book  = i_in.book;
                w_cmd.price = i_in.price;
                if (in_acc) begin
                    w_cmd.act = plb_pkg::ACT_CMP;
                    n_state   = plb_pkg::ST_APPLY;
                end
            end
            plb_pkg::ST_APPLY: begin
                n_state = plb_pkg::ST_RESP;
                if (book_ok) begin
                    case (r_op)
                        plb_pkg::OP_NEW: begin
                            if (r_lvl == 4'd0 || idx > cur_n || idx >= lim) begin
                                n_status = plb_pkg::STS_NEW_BEYOND;
                            end else if (idx < cur_n && eq_idx) begin
                                n_status = plb_pkg::STS_NEW_DUPLICATE;
                            end else begin
                                n_status  = plb_pkg::STS_APPLIED;
                                w_cmd.act = plb_pkg::ACT_INS;
                                w_cmd.hi  = (cur_n >= MAXD) ? MAXD - CW'(1) : cur_n;
                                upd       = 1'b1;
                                new_n     = (cur_n + CW'(1) > lim) ? lim : cur_n + CW'(1);
                                inc       = 1'b1;
                            end
                        end
                        plb_pkg::OP_CHANGE: begin
                            if (r_lvl == 4'd0 || idx >= cur_n || !eq_idx) begin
                                n_status = plb_pkg::STS_CHANGE_MISSING;
                            end else begin
                                n_status  = plb_pkg::STS_APPLIED;
                                w_cmd.act = plb_pkg::ACT_CHG;
                                inc       = 1'b1;
                            end
                        end
                        plb_pkg::OP_DELETE: begin
                            inc      = 1'b1;
                            n_status = plb_pkg::STS_DELETE_MISSING;
                            if (r_lvl != 4'd0 && idx < cur_n && found) begin
                                n_status  = plb_pkg::STS_APPLIED;
                                w_cmd.act = plb_pkg::ACT_DEL;
                                w_cmd.hi  = cur_n - CW'(1);
                                upd       = 1'b1;
                                new_n     = cur_n - CW'(1);
                            end
                        end
                        default: begin
                            n_status = plb_pkg::STS_INVALID;
                        end
                    endcase
                end
            end
            plb_pkg::ST_RESP: begin
                if (out_load) begin
                    n_state = plb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = plb_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plb_pkg::ST_IDLE;
            r_max_depth <= 4'd10;
            r_last      <= '0;
            r_ovalid    <= 1'b0;
            for (int b = 0; b < NUM_BOOKS; b++) begin
                r_valid[b]   <= '0;
                r_applied[b] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_depth <= i_cfg.data;
            end
            if (in_acc) begin
                r_last <= i_in.seq;
                if (regress) begin
                    for (int b = 0; b < NUM_BOOKS; b++) begin
                        r_valid[b]   <= '0;
                        r_applied[b] <= '0;
                    end
                end
            end
            if (r_state == plb_pkg::ST_APPLY) begin
                for (int b = 0; b < NUM_BOOKS; b++) begin
                    if (32'(r_book) == b) begin
                        if (upd) begin
                            r_valid[b] <= new_n;
                        end
                        if (inc) begin
                            r_applied[b] <= cur_cnt + 32'd1;
                        end
                    end
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= plb_pkg::t_op'(i_in.op);
            r_book     <= i_in.book;
            r_lvl      <= i_in.level;
            r_px       <= i_in.price;
            r_qty      <= i_in.quantity;
            r_wasreset <= regress;
        end
        if (r_state == plb_pkg::ST_APPLY) begin
            r_status <= n_status;
        end
        if (out_load) begin
            r_ostatus <= r_status;
            r_oreset  <= r_wasreset;
            if (book_ok) begin
                r_oprice <= (cur_n != '0) ? w_price[0] : 64'sd0;
                r_oqty   <= (cur_n != '0) ? w_qty[0] : 31'd0;
                r_odepth <= cur_n[3:0];
                r_ocount <= cur_cnt;
            end else begin
                r_oprice <= '0;
                r_oqty   <= '0;
                r_odepth <= '0;
                r_ocount <= '0;
            end
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.status           = r_ostatus;
    assign o_out.best_price       = r_oprice;
    assign o_out.best_quantity    = r_oqty;
    assign o_out.depth_known      = r_odepth;
    assign o_out.update_count     = r_ocount;
    assign o_out.books_were_reset = r_oreset;

    // ------------------------------------------------------------ assertions
    a_accept_to_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == plb_pkg::ST_APPLY))
        else $error("accepted transaction did not move to apply");

    a_regress_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && regress) |=> (r_valid[0] == '0 && r_applied[0] == '0))
        else $error("sequence regression did not clear the books");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0] <= MAXD)
        else $error("book depth beyond cell count");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != plb_pkg::ST_IDLE) |-> !i_in.ready)
        else $error("input ready while a transaction is in flight");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out.valid)
        else $error("result register loaded without valid");

endmodule

`default_nettype wire

// File: test/plb_book_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plb_book_checker
// Watches the update, result and config channels, keeps its own copy of the
// four depth books and compares every result transaction field by field
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module plb_book_checker (
    input  wire i_clk,
    input  wire i_rst_n,
    plb_in_if   i_in,
    plb_out_if  i_out,
    plb_cfg_if  i_cfg,
    output int  o_errors,
    output int  o_pending
);

    localparam int DEPTH_MAX  = 10;
    localparam int BOOK_COUNT = 4;

    typedef struct packed {
        plb_pkg::t_status   status;
        logic signed [63:0] best_price;
        logic [30:0]        best_quantity;
        logic [3:0]         depth_known;
        logic [31:0]        update_count;
        logic               books_were_reset;
    } t_book_summary;

    logic signed [63:0] level_px [BOOK_COUNT][DEPTH_MAX];
    logic [30:0]        level_qty [BOOK_COUNT][DEPTH_MAX];
    int                 book_depth [BOOK_COUNT];
    logic [31:0]        book_updates [BOOK_COUNT];
    logic [31:0]        last_seq;
    logic [3:0]         depth_setting;
    t_book_summary      pending_summaries [$];
    int                 error_count = 0;
    int                 pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    function automatic t_book_summary apply_book_update(
        input plb_pkg::t_op       op,
        input logic [1:0]         book,
        input logic [3:0]         level,
        input logic signed [63:0] price,
        input logic [30:0]        qty,
        input logic [31:0]        seq
    );
        t_book_summary s;
        int            b, idx, n, lim, i;
        bit            found;
        s        = '0;
        s.status = plb_pkg::STS_INVALID;
        b        = int'(book);
        idx      = int'(level) - 1;
        lim      = (depth_setting == 0) ? 1 :
                   ((int'(depth_setting) > DEPTH_MAX) ? DEPTH_MAX : int'(depth_setting));
        if (seq < last_seq) begin
            for (i = 0; i < BOOK_COUNT; i++) begin
                book_depth[i]   = 0;
                book_updates[i] = '0;
            end
            s.books_were_reset = 1'b1;
        end
        last_seq = seq;
        if (b >= BOOK_COUNT) return s;
        n = book_depth[b];
        case (op)
            plb_pkg::OP_NEW: begin
                if (level == 0 || idx > n || idx >= lim) begin
                    s.status = plb_pkg::STS_NEW_BEYOND;
                end else if (idx < n && level_px[b][idx] == price) begin
                    s.status = plb_pkg::STS_NEW_DUPLICATE;
                end else begin
                    if (n >= DEPTH_MAX) n = DEPTH_MAX - 1;
                    for (i = n; i > idx; i--) begin
                        level_px[b][i]  = level_px[b][i-1];
                        level_qty[b][i] = level_qty[b][i-1];
                    end
                    level_px[b][idx]  = price;
                    level_qty[b][idx] = qty;
                    book_depth[b]     = (n + 1 > lim) ? lim : n + 1;
                    book_updates[b]   = book_updates[b] + 1;
                    s.status          = plb_pkg::STS_APPLIED;
                end
            end
            plb_pkg::OP_CHANGE: begin
                if (level == 0 || idx >= n || level_px[b][idx] != price) begin
                    s.status = plb_pkg::STS_CHANGE_MISSING;
                end else begin
                    level_qty[b][idx] = qty;
                    book_updates[b]   = book_updates[b] + 1;
                    s.status          = plb_pkg::STS_APPLIED;
                end
            end
            plb_pkg::OP_DELETE: begin
                found = 1'b0;
                for (i = 0; i < n; i++) begin
                    if (level_px[b][i] == price) found = 1'b1;
                end
                // counted even when nothing is removed
                book_updates[b] = book_updates[b] + 1;
                if (level != 0 && idx < n && found) begin
                    for (i = idx; i + 1 < n; i++) begin
                        level_px[b][i]  = level_px[b][i+1];
                        level_qty[b][i] = level_qty[b][i+1];
                    end
                    book_depth[b] = n - 1;
                    s.status      = plb_pkg::STS_APPLIED;
                end else begin
                    s.status = plb_pkg::STS_DELETE_MISSING;
                end
            end
            default: s.status = plb_pkg::STS_INVALID;
        endcase
        if (book_depth[b] > 0) begin
            s.best_price    = level_px[b][0];
            s.best_quantity = level_qty[b][0];
        end
        s.depth_known  = 4'(book_depth[b]);
        s.update_count = book_updates[b];
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_book_summary want;
        t_book_summary next_summary;
        if (!i_rst_n) begin
            for (int i = 0; i < BOOK_COUNT; i++) begin
                book_depth[i]   = 0;
                book_updates[i] = '0;
            end
            last_seq      = '0;
            depth_setting = 4'd10;
            pending_summaries.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pending_summaries.size() == 0) begin
                    $error("result transaction with no update outstanding");
                    error_count++;
                end else begin
                    want = pending_summaries.pop_front();
                    check_field("status", want.status, i_out.status);
                    check_field("best_price", want.best_price, i_out.best_price);
                    check_field("best_quantity", want.best_quantity, i_out.best_quantity);
                    check_field("depth_known", want.depth_known, i_out.depth_known);
                    check_field("update_count", want.update_count, i_out.update_count);
                    check_field("books_were_reset", want.books_were_reset,
                                i_out.books_were_reset);
                end
            end
            if (i_cfg.valid && i_cfg.ready) depth_setting = i_cfg.data;
            if (i_in.valid && i_in.ready) begin
                next_summary = apply_book_update(plb_pkg::t_op'(i_in.op), i_in.book,
                    i_in.level, i_in.price, i_in.quantity, i_in.seq);
                pending_summaries = {pending_summaries, next_summary};
            end
        end
        pending_count = pending_summaries.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives book updates and max depth writes into the depth book with random
// gaps and result stalls, including a long result hold-off, and reports the
// verdict from the checker's failure count, or an error on an idle timeout.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 150;

    localparam logic signed [63:0] PX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] PX_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic [30:0]        QTY_MAX = 31'h7FFF_FFFF;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    int                 errors;
    int                 pending;
    int                 idle_cycles = 0;
    bit                 in_steady = 1'b0;
    bit                 out_steady = 1'b0;
    bit                 hold_request = 1'b0;
    logic signed [63:0] price_pool [4];

    plb_in_if  in_ch ();
    plb_out_if out_ch ();
    plb_cfg_if cfg_ch ();

    price_level_depth_book_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    plb_book_checker book_check (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int draw_gap(input bit steady);
        if (steady || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic signed [63:0] pick_price();
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        return price_pool[$urandom_range(0, 3)];
    endfunction

    task automatic send_update(input plb_pkg::t_op op, input logic [1:0] book,
                               input logic [3:0] level,
                               input logic signed [63:0] price, input logic [30:0] qty,
                               input logic [31:0] seq);
        int gap;
        gap = draw_gap(in_steady);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.op       = op;
        in_ch.book     = book;
        in_ch.level    = level;
        in_ch.price    = price;
        in_ch.quantity = qty;
        in_ch.seq      = seq;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // only while no update is in flight
    task automatic write_max_depth(input logic [3:0] value);
        in_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // result side
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = draw_gap(out_steady);
            end
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        int           ph, k, r;
        plb_pkg::t_op op;
        logic [3:0]   level;
        logic [30:0]  qty;
        logic [31:0]  seq;
        logic [3:0]   depth_plan [PHASES];

        in_ch.valid    = 1'b0;
        in_ch.op       = plb_pkg::OP_NEW;
        in_ch.book     = '0;
        in_ch.level    = '0;
        in_ch.price    = '0;
        in_ch.quantity = '0;
        in_ch.seq      = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: status codes, extremes, regression, full book, depth register
        send_update(plb_pkg::OP_NEW,     2'd0, 4'd1,  PX_MAX, QTY_MAX, 32'd100);
        send_update(plb_pkg::OP_NEW,     2'd0, 4'd1,  PX_MIN, 31'd0,   32'd100);
        send_update(plb_pkg::OP_NEW,     2'd0, 4'd1,  PX_MIN, 31'd7,   32'd101);
        send_update(plb_pkg::OP_NEW,     2'd0, 4'd4,  64'sd0, 31'd7,   32'd101);
        send_update(plb_pkg::OP_NEW,     2'd0, 4'd0,  64'sd0, 31'd7,   32'd102);
        send_update(plb_pkg::OP_CHANGE,  2'd0, 4'd2,  PX_MAX, 31'd5,   32'd102);
        send_update(plb_pkg::OP_CHANGE,  2'd0, 4'd2,  64'sd0, 31'd5,   32'd103);
        send_update(plb_pkg::OP_CHANGE,  2'd0, 4'd0,  PX_MAX, 31'd5,   32'd103);
        send_update(plb_pkg::OP_DELETE,  2'd0, 4'd0,  PX_MIN, 31'd0,   32'd104);
        send_update(plb_pkg::OP_DELETE,  2'd0, 4'd2,  64'sd12345, 31'd0, 32'd104);
        send_update(plb_pkg::OP_DELETE,  2'd0, 4'd2,  PX_MIN, 31'd0,   32'd105);
        send_update(plb_pkg::OP_INVALID, 2'd1, 4'd1,  -64'sd1, QTY_MAX, 32'd105);
        send_update(plb_pkg::OP_NEW,     2'd3, 4'd15, -64'sd1, 31'd1,  32'd106);
        send_update(plb_pkg::OP_NEW,     2'd2, 4'd1,  -64'sd1, QTY_MAX, 32'd50);
        send_update(plb_pkg::OP_CHANGE,  2'd2, 4'd1,  -64'sd1, 31'd0,  32'd50);
        write_max_depth(4'd2);
        send_update(plb_pkg::OP_NEW,     2'd1, 4'd1,  64'sd1, 31'd10,  32'd51);
        send_update(plb_pkg::OP_NEW,     2'd1, 4'd1,  64'sd2, 31'd20,  32'd52);
        send_update(plb_pkg::OP_NEW,     2'd1, 4'd1,  64'sd3, 31'd30,  32'd53);
        send_update(plb_pkg::OP_NEW,     2'd1, 4'd3,  64'sd4, 31'd40,  32'd54);
        write_max_depth(4'd0);
        send_update(plb_pkg::OP_CHANGE,  2'd1, 4'd2,  64'sd2, 31'd21,  32'd55);
        send_update(plb_pkg::OP_NEW,     2'd1, 4'd1,  64'sd4, 31'd40,  32'd56);
        send_update(plb_pkg::OP_NEW,     2'd1, 4'd2,  64'sd5, 31'd50,  32'd57);
        write_max_depth(4'd15);
        send_update(plb_pkg::OP_NEW,     2'd1, 4'd2,  64'sd5, 31'd50,  32'hFFFF_FFFF);
        send_update(plb_pkg::OP_DELETE,  2'd1, 4'd1,  64'sd5, 31'd0,   32'hFFFF_FFFF);

        depth_plan = '{4'd10, 4'd1, 4'd15, 4'd0, 4'd3, 4'd10, 4'($urandom_range(0, 15))};
        for (ph = 0; ph < PHASES; ph++) begin
            write_max_depth(depth_plan[ph]);
            in_steady  = (ph == 1 || ph == 3);
            out_steady = (ph == 1);
            if (ph == 3) hold_request = 1'b1;
            for (k = 0; k < 4; k++) begin
                case ($urandom_range(0, 5))
                    0:       price_pool[k] = PX_MAX;
                    1:       price_pool[k] = PX_MIN;
                    2:       price_pool[k] = 64'($urandom_range(0, 20)) - 64'sd10;
                    default: price_pool[k] = {$urandom, $urandom};
                endcase
            end
            seq = $urandom;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 45)      op = plb_pkg::OP_NEW;
                else if (r < 65) op = plb_pkg::OP_CHANGE;
                else if (r < 88) op = plb_pkg::OP_DELETE;
                else             op = plb_pkg::OP_INVALID;
                r = $urandom_range(0, 99);
                if (r < 60)      level = 4'($urandom_range(1, 3));
                else if (r < 90) level = 4'($urandom_range(1, 11));
                else             level = 4'($urandom_range(0, 15));
                r = $urandom_range(0, 9);
                if (r == 0)      qty = '0;
                else if (r == 1) qty = QTY_MAX;
                else             qty = 31'($urandom);
                if ($urandom_range(0, 99) < 2 && seq != 0) seq = $urandom_range(0, seq - 1);
                else                                       seq = seq + $urandom_range(0, 2);
                send_update(op, 2'($urandom_range(0, 3)), level, pick_price(), qty, seq);
            end
        end

        in_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (10) @(negedge clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
